>>> rtl/lmts_pkg.sv
// Package for the longest-match token scanner: sizes, codes, the vocabulary
// entry type and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none
package lmts_pkg;

   localparam int MAX_TOKEN_BYTES = 8;
   localparam int VOCAB_ENTRIES   = 256;
   localparam int VIDX_W          = $clog2(VOCAB_ENTRIES);
   localparam int VCNT_W          = $clog2(VOCAB_ENTRIES + 1);
   localparam int WIDX_W          = $clog2(MAX_TOKEN_BYTES);
   localparam int LEN_W           = 4;
   localparam int TOKEN_W         = 64;
   localparam int ID_W            = 16;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_STREAM = 2'd1,
      MODE_END    = 2'd2
   } mode_type;

   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_ACK   = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [1:0] LS_NEW      = 2'd0;
   localparam logic [1:0] LS_REPLACED = 2'd1;
   localparam logic [1:0] LS_DROPPED  = 2'd2;

   typedef enum logic [1:0] {
      SK_LOAD,
      SK_MARKER,
      SK_LONGEST
   } scan_kind_type;

   typedef enum logic [2:0] {
      OS_ACK_BAD,
      OS_ACK,
      OS_MATCH,
      OS_PEND,
      OS_PEND_LAST,
      OS_EMPTY_END
   } out_sel_type;

   typedef struct packed {
      logic                 ld_latch;
      logic                 append;
      logic                 scan_start;
      scan_kind_type        scan_kind;
      logic                 scan_run;
      logic                 consume;
      logic                 cons_ws;
      logic                 vocab_write;
      logic                 out_load;
      out_sel_type          out_sel;
      logic                 pend_set;
      logic                 pend_clr;
   } cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0] fill;
      logic             front_ws;
      logic             marker_hit;
      logic             ld_bad;
      logic             scan_done;
      logic             found;
      logic             pend_vld;
   } stat_type;

   typedef struct packed {
      logic [TOKEN_W-1:0] bytes;
      logic [LEN_W-1:0]   len;
      logic [ID_W-1:0]    id;
   } entry_type;

   // Keeps the low len bytes of a packed token.
   function automatic logic [TOKEN_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [TOKEN_W-1:0] m;
      m = '0;
      for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
         if (LEN_W'(k) < len) m[8*k +: 8] = 8'hFF;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

>>> rtl/lmts_if.sv
// Valid/ready channel interfaces for the token scanner's items and results.
// Depends on nothing.
`default_nettype none
interface lmts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  data_byte;
   logic [63:0] entry_token;
   logic [3:0]  entry_length;
   logic [15:0] entry_id;
   modport source (output valid, mode, data_byte, entry_token, entry_length, entry_id,
                   input ready);
   modport sink   (input valid, mode, data_byte, entry_token, entry_length, entry_id,
                   output ready);
endinterface

interface lmts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] token_id;
   logic [1:0]  load_status;
   logic        last_of_run;
   modport source (output valid, result_kind, token_id, load_status, last_of_run,
                   input ready);
   modport sink   (input valid, result_kind, token_id, load_status, last_of_run,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/lmts_dp.sv
// Datapath of the token scanner: vocabulary memory, lookahead window, scan
// pipeline, pending result and output register. Depends on lmts_pkg.
`default_nettype none
module lmts_dp (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [7:0]                   data_byte,
   input  wire  [lmts_pkg::TOKEN_W-1:0] entry_token,
   input  wire  [lmts_pkg::LEN_W-1:0]   entry_length,
   input  wire  [lmts_pkg::ID_W-1:0]    entry_id,
   input  wire  lmts_pkg::cmd_type      cmd,
   output lmts_pkg::stat_type           stat,
   output logic [1:0]                   result_kind,
   output logic [lmts_pkg::ID_W-1:0]    token_id,
   output logic [1:0]                   load_status,
   output logic                         last_of_run
);
   localparam int MAXB = lmts_pkg::MAX_TOKEN_BYTES;

   lmts_pkg::entry_type vocab_mem [lmts_pkg::VOCAB_ENTRIES];
   lmts_pkg::entry_type rd_ff;

   logic [lmts_pkg::VCNT_W-1:0]  cnt_ff, cnt_in;
   logic [lmts_pkg::VCNT_W-1:0]  idx_ff, idx_in;
   logic [lmts_pkg::VIDX_W-1:0]  pipe_idx_ff;
   logic                         pipe_vld_ff, pipe_vld_in;
   logic                         found_ff, found_in;
   logic [lmts_pkg::LEN_W-1:0]   best_len_ff, best_len_in;
   logic [lmts_pkg::ID_W-1:0]    best_id_ff, best_id_in;
   logic [lmts_pkg::VIDX_W-1:0]  best_idx_ff, best_idx_in;
   logic                         scan_load_ff, scan_load_in;
   logic [lmts_pkg::LEN_W-1:0]   tgt_ff, tgt_in;

   logic [lmts_pkg::TOKEN_W-1:0] ld_bytes_ff;
   logic [lmts_pkg::LEN_W-1:0]   ld_len_ff;
   logic [lmts_pkg::ID_W-1:0]    ld_id_ff;

   logic [7:0]                   win_ff [MAXB];
   logic [7:0]                   win_in [MAXB];
   logic [lmts_pkg::LEN_W-1:0]   fill_ff, fill_in;

   logic                         pend_vld_ff, pend_vld_in;
   logic [lmts_pkg::ID_W-1:0]    pend_id_ff;

   logic [1:0]                   kind_ff, kind_in;
   logic [lmts_pkg::ID_W-1:0]    id_ff, id_in;
   logic [1:0]                   status_ff, status_in;
   logic                         last_ff, last_in;

   logic [lmts_pkg::TOKEN_W-1:0] win_packed;
   logic                         table_full;
   logic                         wr_en;
   logic [lmts_pkg::VIDX_W-1:0]  wr_addr;
   logic                         ld_hit, tk_hit, hit;
   logic                         m_hit;
   logic [lmts_pkg::LEN_W-1:0]   m_len;
   logic                         ws;
   logic [lmts_pkg::LEN_W-1:0]   skip_n, cons_n;
   logic [7:0]                   w0, w1, w2;
   logic [lmts_pkg::LEN_W:0]     src;

   assign table_full = (cnt_ff == lmts_pkg::VCNT_W'(lmts_pkg::VOCAB_ENTRIES));
   assign wr_en      = found_ff || !table_full;
   assign wr_addr    = found_ff ? best_idx_ff : cnt_ff[lmts_pkg::VIDX_W-1:0];

   always_comb begin
      for (int k = 0; k < MAXB; k++) win_packed[8*k +: 8] = win_ff[k];
   end

   assign w0 = win_ff[0];
   assign w1 = win_ff[1];
   assign w2 = win_ff[2];

   // Skip markers in priority order; each must lie fully inside the window.
   always_comb begin
      m_hit = 1'b1;
      m_len = lmts_pkg::LEN_W'(2);
      if (fill_ff >= 2 && w0 == 8'hCB && w1 == 8'h88) begin
         m_len = lmts_pkg::LEN_W'(2);
      end else if (fill_ff >= 2 && w0 == 8'hCB && w1 == 8'h8C) begin
         m_len = lmts_pkg::LEN_W'(2);
      end else if (fill_ff >= 3 && w0 == 8'hE2 && w1 == 8'h80 && w2 == 8'h96) begin
         m_len = lmts_pkg::LEN_W'(3);
      end else if (fill_ff >= 1 && w0 == 8'h7C) begin
         m_len = lmts_pkg::LEN_W'(1);
      end else if (fill_ff >= 1 && w0 == 8'h2E) begin
         m_len = lmts_pkg::LEN_W'(1);
      end else if (fill_ff >= 2 && w0 == 8'hCB && w1 == 8'h90) begin
         m_len = lmts_pkg::LEN_W'(2);
      end else begin
         m_hit = 1'b0;
      end
   end

   assign ws = (fill_ff != '0) && (w0 == 8'h20 || (w0 >= 8'h09 && w0 <= 8'h0D));

   // Codepoint length from the UTF-8 lead byte.
   always_comb begin
      if ((w0 & 8'h80) == 8'h00)      skip_n = lmts_pkg::LEN_W'(1);
      else if ((w0 & 8'hE0) == 8'hC0) skip_n = lmts_pkg::LEN_W'(2);
      else if ((w0 & 8'hF0) == 8'hE0) skip_n = lmts_pkg::LEN_W'(3);
      else if ((w0 & 8'hF8) == 8'hF0) skip_n = lmts_pkg::LEN_W'(4);
      else                            skip_n = lmts_pkg::LEN_W'(1);
   end

   always_comb begin
      if (cmd.cons_ws)      cons_n = lmts_pkg::LEN_W'(1);
      else if (found_ff)    cons_n = best_len_ff;
      else if (tgt_ff != 0) cons_n = tgt_ff;
      else                  cons_n = skip_n;
   end

   assign ld_hit = (rd_ff.len == ld_len_ff) && (rd_ff.bytes == ld_bytes_ff);
   assign tk_hit = (rd_ff.len != '0) && (rd_ff.len <= fill_ff)
                   && (tgt_ff == '0 || rd_ff.len == tgt_ff)
                   && (rd_ff.bytes == (win_packed & lmts_pkg::byte_mask(rd_ff.len)));
   assign hit    = pipe_vld_ff && (scan_load_ff ? ld_hit : tk_hit)
                   && (!found_ff || rd_ff.len > best_len_ff);

   always_comb begin
      idx_in       = idx_ff;
      pipe_vld_in  = 1'b0;
      found_in     = found_ff;
      best_len_in  = best_len_ff;
      best_id_in   = best_id_ff;
      best_idx_in  = best_idx_ff;
      scan_load_in = scan_load_ff;
      tgt_in       = tgt_ff;
      cnt_in       = cnt_ff;
      pend_vld_in  = pend_vld_ff;
      if (cmd.scan_start) begin
         idx_in       = '0;
         found_in     = 1'b0;
         scan_load_in = (cmd.scan_kind == lmts_pkg::SK_LOAD);
         tgt_in       = (cmd.scan_kind == lmts_pkg::SK_MARKER) ? m_len : '0;
      end
      if (cmd.scan_run) begin
         if (idx_ff != cnt_ff) begin
            idx_in      = idx_ff + 1'b1;
            pipe_vld_in = 1'b1;
         end
         if (hit) begin
            found_in    = 1'b1;
            best_len_in = rd_ff.len;
            best_id_in  = rd_ff.id;
            best_idx_in = pipe_idx_ff;
         end
      end
      if (cmd.vocab_write && !found_ff && !table_full) cnt_in = cnt_ff + 1'b1;
      if (cmd.pend_set) pend_vld_in = 1'b1;
      if (cmd.pend_clr) pend_vld_in = 1'b0;
   end

   always_comb begin
      for (int k = 0; k < MAXB; k++) win_in[k] = win_ff[k];
      fill_in = fill_ff;
      src     = '0;
      if (cmd.append) begin
         win_in[fill_ff[lmts_pkg::WIDX_W-1:0]] = data_byte;
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.consume) begin
         for (int k = 0; k < MAXB; k++) begin
            src = (lmts_pkg::LEN_W+1)'(k) + {1'b0, cons_n};
            if (src < (lmts_pkg::LEN_W+1)'(MAXB)) win_in[k] = win_ff[src[lmts_pkg::WIDX_W-1:0]];
         end
         fill_in = (cons_n >= fill_ff) ? '0 : fill_ff - cons_n;
      end
   end

   // Result fields for the selected result source.
   always_comb begin
      kind_in   = lmts_pkg::KIND_TOKEN;
      id_in     = '0;
      status_in = lmts_pkg::LS_NEW;
      last_in   = 1'b0;
      case (cmd.out_sel)
         lmts_pkg::OS_ACK_BAD: begin
            kind_in   = lmts_pkg::KIND_ACK;
            status_in = lmts_pkg::LS_DROPPED;
         end
         lmts_pkg::OS_ACK: begin
            kind_in = lmts_pkg::KIND_ACK;
            if (found_ff)         status_in = lmts_pkg::LS_REPLACED;
            else if (table_full)  status_in = lmts_pkg::LS_DROPPED;
            else                  status_in = lmts_pkg::LS_NEW;
         end
         lmts_pkg::OS_MATCH: id_in = best_id_ff;
         lmts_pkg::OS_PEND:  id_in = pend_id_ff;
         lmts_pkg::OS_PEND_LAST: begin
            id_in   = pend_id_ff;
            last_in = 1'b1;
         end
         lmts_pkg::OS_EMPTY_END: begin
            kind_in = lmts_pkg::KIND_END;
            last_in = 1'b1;
         end
         default: kind_in = lmts_pkg::KIND_END;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.vocab_write && wr_en) begin
         vocab_mem[wr_addr] <= '{bytes: ld_bytes_ff, len: ld_len_ff, id: ld_id_ff};
      end
      rd_ff <= vocab_mem[idx_ff[lmts_pkg::VIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         idx_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         scan_load_ff <= 1'b0;
         tgt_ff       <= '0;
         fill_ff      <= '0;
         pend_vld_ff  <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         pipe_vld_ff  <= pipe_vld_in;
         found_ff     <= found_in;
         scan_load_ff <= scan_load_in;
         tgt_ff       <= tgt_in;
         fill_ff      <= fill_in;
         pend_vld_ff  <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff <= idx_ff[lmts_pkg::VIDX_W-1:0];
      best_len_ff <= best_len_in;
      best_id_ff  <= best_id_in;
      best_idx_ff <= best_idx_in;
      for (int k = 0; k < MAXB; k++) win_ff[k] <= win_in[k];
      if (cmd.ld_latch) begin
         ld_bytes_ff <= entry_token & lmts_pkg::byte_mask(entry_length);
         ld_len_ff   <= entry_length;
         ld_id_ff    <= entry_id;
      end
      if (cmd.pend_set) pend_id_ff <= best_id_ff;
      if (cmd.out_load) begin
         kind_ff   <= kind_in;
         id_ff     <= id_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign stat.fill       = fill_ff;
   assign stat.front_ws   = ws;
   assign stat.marker_hit = m_hit;
   assign stat.ld_bad     = (ld_len_ff == '0) || (ld_len_ff > lmts_pkg::LEN_W'(MAXB));
   assign stat.scan_done  = (idx_ff == cnt_ff) && !pipe_vld_ff;
   assign stat.found      = found_ff;
   assign stat.pend_vld   = pend_vld_ff;

   assign result_kind = kind_ff;
   assign token_id    = id_ff;
   assign load_status = status_ff;
   assign last_of_run = last_ff;

endmodule
`default_nettype wire

>>> rtl/lmts_ctrl.sv
// Controller of the token scanner: sequences loads, scan steps, the end drain
// and result handoff. Depends on lmts_pkg.
`default_nettype none
module lmts_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire  [1:0]          req_mode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   input  wire lmts_pkg::stat_type stat,
   output lmts_pkg::cmd_type   cmd
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD_CHK,
      S_LOAD_SCAN,
      S_STEP,
      S_SCAN,
      S_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      end_ff, end_in;
   logic      ret_step_ff, ret_step_in;
   logic      take;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign take      = req_valid && req_ready;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      end_in      = end_ff;
      ret_step_in = ret_step_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (req_mode)
                  lmts_pkg::MODE_LOAD: begin
                     cmd.ld_latch = 1'b1;
                     state_in     = S_LOAD_CHK;
                  end
                  lmts_pkg::MODE_STREAM: begin
                     cmd.append = 1'b1;
                     end_in     = 1'b0;
                     if (stat.fill == lmts_pkg::LEN_W'(lmts_pkg::MAX_TOKEN_BYTES - 1)) begin
                        state_in = S_STEP;
                     end
                  end
                  lmts_pkg::MODE_END: begin
                     end_in   = 1'b1;
                     state_in = S_STEP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD_CHK: begin
            ret_step_in = 1'b0;
            if (stat.ld_bad) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = lmts_pkg::OS_ACK_BAD;
               state_in     = S_SEND;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_kind  = lmts_pkg::SK_LOAD;
               state_in       = S_LOAD_SCAN;
            end
         end
         S_LOAD_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               cmd.vocab_write = 1'b1;
               cmd.out_load    = 1'b1;
               cmd.out_sel     = lmts_pkg::OS_ACK;
               state_in        = S_SEND;
            end
         end
         S_STEP: begin
            if (stat.fill == '0) begin
               // Drain finished: flag the held result, or report an empty run.
               cmd.out_load = 1'b1;
               cmd.out_sel  = stat.pend_vld ? lmts_pkg::OS_PEND_LAST
                                            : lmts_pkg::OS_EMPTY_END;
               cmd.pend_clr = 1'b1;
               ret_step_in  = 1'b0;
               state_in     = S_SEND;
            end else if (stat.front_ws) begin
               cmd.consume = 1'b1;
               cmd.cons_ws = 1'b1;
               state_in    = end_ff ? S_STEP : S_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_kind  = stat.marker_hit ? lmts_pkg::SK_MARKER
                                                : lmts_pkg::SK_LONGEST;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               cmd.consume = 1'b1;
               if (stat.found && !end_ff) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = lmts_pkg::OS_MATCH;
                  ret_step_in  = 1'b0;
                  state_in     = S_SEND;
               end else if (stat.found) begin
                  // During a drain a result is held back one step so that the
                  // final one can carry the last flag.
                  cmd.pend_set = 1'b1;
                  if (stat.pend_vld) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = lmts_pkg::OS_PEND;
                     ret_step_in  = 1'b1;
                     state_in     = S_SEND;
                  end else begin
                     state_in = S_STEP;
                  end
               end else begin
                  state_in = end_ff ? S_STEP : S_IDLE;
               end
            end
         end
         S_SEND: begin
            if (rsp_ready) state_in = ret_step_ff ? S_STEP : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         end_ff      <= 1'b0;
         ret_step_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         end_ff      <= end_in;
         ret_step_ff <= ret_step_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/longest_match_token_scanner_core.sv
// Top level of the longest-match token scanner: controller plus datapath.
// Depends on lmts_pkg, lmts_if, lmts_ctrl and lmts_dp.
//
//   channel   direction  carries
//   req_ch    in         load entry, stream byte or end of stream
//   rsp_ch    out        token id, load acknowledge or end marker
//
// One item is handled at a time. A load or a scan step walks the stored
// vocabulary one entry per cycle. A stream byte that does not fill the window
// is only appended to it; an end item runs up to seven scan steps. Each result
// waits in the output register until taken, and no new item is accepted
// meanwhile. Synchronous reset empties the vocabulary and the window without
// a clearing pass.
`default_nettype none
module longest_match_token_scanner_core (
   input  wire         clock,
   input  wire         reset,
   lmts_req_if.sink    req_ch,
   lmts_rsp_if.source  rsp_ch
);
   lmts_pkg::cmd_type  cmd;
   lmts_pkg::stat_type stat;

   lmts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lmts_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .data_byte    (req_ch.data_byte),
      .entry_token  (req_ch.entry_token),
      .entry_length (req_ch.entry_length),
      .entry_id     (req_ch.entry_id),
      .cmd          (cmd),
      .stat         (stat),
      .result_kind  (rsp_ch.result_kind),
      .token_id     (rsp_ch.token_id),
      .load_status  (rsp_ch.load_status),
      .last_of_run  (rsp_ch.last_of_run)
   );

`ifndef SYNTHESIS
   a_no_take_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready) else $error("item taken while a result waits");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stat.fill <= 4'(lmts_pkg::MAX_TOKEN_BYTES)) else $error("window overfilled");
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last_of_run |-> rsp_ch.result_kind != lmts_pkg::KIND_ACK)
      else $error("last flag on a load acknowledge");
   a_pend_empty_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.last_of_run |-> !stat.pend_vld && stat.fill == '0)
      else $error("drain ended with state left over");
`endif

endmodule
`default_nettype wire
